// ----- src/armavg_pkg.sv -----
// Shared constants and types for the angular rate moving average.
`timescale 1ns / 1ps
`default_nettype none

package armavg_pkg;

  // Axes: yaw, pitch, roll
  localparam int AXES   = 3;
  localparam int AXIS_W = 2;

  // Ring depth per axis
  localparam int WINDOW_DEPTH = 10;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int FREQ_W  = 16;
  localparam int STAMP_W = 32;
  localparam int RATE_W  = 28;

  // Internal widths
  localparam int DIFF_W = ANGLE_W + 1;
  localparam int PROD_W = ANGLE_W + FREQ_W + 1;
  localparam int SUM_W  = RATE_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_W  = SUM_W;
  localparam int BITC_W = $clog2(DIV_W);

  // Half and full turn in 1/128 degree
  localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd23040;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd46080;

  // Q.11 deg/s to Q.7 deg/s, round half up
  localparam logic signed [PROD_W-1:0] RND_BIAS   = 33'sd8;
  localparam int                       FRAC_SHIFT = 4;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [FREQ_W-1:0]  freq_t;
  typedef logic        [STAMP_W-1:0] stamp_t;
  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [DIV_W-1:0]   quo_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [SLOT_W-1:0]  slot_t;

  // One ring row holds the rate of every axis
  typedef logic [AXES-1:0][RATE_W-1:0] rate_row_t;

endpackage

`default_nettype wire

// ----- src/armavg_if.sv -----
// Valid/ready channel interfaces for compass ticks and averaged rates.
`timescale 1ns / 1ps
`default_nettype none

interface armavg_in_if;
  import armavg_pkg::*;

  logic   valid;
  logic   ready;
  logic   sample_valid;
  angle_t yaw_angle;
  angle_t pitch_angle;
  angle_t roll_angle;
  stamp_t sample_time;
  freq_t  loop_rate;

  modport source (
    output valid, sample_valid, yaw_angle, pitch_angle, roll_angle, sample_time, loop_rate,
    input  ready
  );

  modport sink (
    input  valid, sample_valid, yaw_angle, pitch_angle, roll_angle, sample_time, loop_rate,
    output ready
  );
endinterface

interface armavg_out_if;
  import armavg_pkg::*;

  logic   valid;
  logic   ready;
  rate_t  yaw_rate;
  rate_t  pitch_rate;
  rate_t  roll_rate;
  stamp_t rate_time;

  modport source (
    output valid, yaw_rate, pitch_rate, roll_rate, rate_time,
    input  ready
  );

  modport sink (
    input  valid, yaw_rate, pitch_rate, roll_rate, rate_time,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/angular_rate_moving_average.sv -----
// Top level: angular rate moving average over a ring of per-axis rates.
`timescale 1ns / 1ps
`default_nettype none

// Takes compass ticks (yaw, pitch, roll in 1/128 degree) and gives, for each
// tick with a nonzero loop rate, the mean angular rate per axis over the last
// WINDOW_DEPTH ticks (fewer while the ring fills), in 1/128 deg/s, together
// with the timestamp of the latest valid reading. A tick with zero loop rate
// is taken and gives no word. Any other tick passes the difference, multiply
// and round, sum update, divider set-up, divide and final states in order:
// one shared 17x16 multiplier serves the three axes in turn, and three
// bit-serial dividers work one quotient bit a cycle over SUM_W bits. A new
// tick is taken once the previous one has left for the output register; the
// result word waits there for its sink. The rate ring is one synchronous
// memory of WINDOW_DEPTH rows, read once and written once per tick; a row
// read before it has been written is ignored.
module angular_rate_moving_average (
  input  wire           clk,
  input  wire           rst,
  armavg_in_if.sink     sample_in,
  armavg_out_if.source  rate_out
);
  import armavg_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIFF = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_RND  = 8'b0000_1000,
    ST_UPD  = 8'b0001_0000,
    ST_DSET = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t             state;
  logic               in_acc;

  // Angle state
  angle_t             cur_ang  [AXES];
  angle_t             prev_ang [AXES];
  stamp_t             cur_stamp;

  // Per-tick working registers
  freq_t              freq_q;
  angle_t             diff_q   [AXES];
  prod_t              prod_q;
  logic [AXIS_W-1:0]  axis;
  rate_t              rate_new [AXES];

  // Ring bookkeeping
  sum_t               sums     [AXES];
  slot_t              slot;
  logic               full_q;
  cnt_t               count_q;

  // Rate ring
  rate_row_t          hist_mem [WINDOW_DEPTH];
  rate_row_t          rd_row;

  // Divider lanes
  logic [CNT_W-1:0]   rem      [AXES];
  quo_t               quo      [AXES];
  logic               neg      [AXES];
  logic [BITC_W-1:0]  bit_cnt;

  // Output register
  logic               out_valid_q;
  rate_t              out_rate [AXES];
  stamp_t             out_stamp;

  // Combinational helpers
  diff_t              d_raw    [AXES];
  angle_t             d_wrap   [AXES];
  prod_t              prod_rnd;
  prod_t              prod_shr;
  sum_t               old_rate [AXES];
  sum_t               sum_upd  [AXES];
  quo_t               mag      [AXES];
  logic [CNT_W:0]     shifted  [AXES];
  logic               fits     [AXES];
  logic [CNT_W-1:0]   rem_next [AXES];
  quo_t               quo_next [AXES];
  quo_t               res      [AXES];
  rate_row_t          wr_row;
  cnt_t               slot_inc;
  logic               wrap_end;

  assign in_acc          = sample_in.valid && sample_in.ready;
  assign sample_in.ready = (state == ST_IDLE);

  assign rate_out.valid      = out_valid_q;
  assign rate_out.yaw_rate   = out_rate[0];
  assign rate_out.pitch_rate = out_rate[1];
  assign rate_out.roll_rate  = out_rate[2];
  assign rate_out.rate_time  = out_stamp;

  // Axis difference, wrapped into one half turn either way
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d_raw[a] = $signed({cur_ang[a][ANGLE_W-1], cur_ang[a]})
               - $signed({prev_ang[a][ANGLE_W-1], prev_ang[a]});
      if (d_raw[a] > HALF_TURN) begin
        d_wrap[a] = angle_t'(d_raw[a] - FULL_TURN);
      end else if (d_raw[a] < -HALF_TURN) begin
        d_wrap[a] = angle_t'(d_raw[a] + FULL_TURN);
      end else begin
        d_wrap[a] = angle_t'(d_raw[a]);
      end
    end
  end

  // Q.11 product to Q.7 rate; magnitude stays inside the rate bound
  always_comb begin
    prod_rnd = prod_q + RND_BIAS;
    prod_shr = prod_rnd >>> FRAC_SHIFT;
  end

  // Running sums, ring row and fill count
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      old_rate[a] = full_q ? sum_t'($signed(rd_row[a])) : '0;
      sum_upd[a]  = sums[a] + sum_t'(rate_new[a]) - old_rate[a];
      wr_row[a]   = rate_new[a];
    end
    slot_inc = cnt_t'(slot) + 1'b1;
    wrap_end = (slot_inc == cnt_t'(WINDOW_DEPTH));
  end

  // Divider: magnitude set-up, one restoring step, signed result
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      mag[a]      = (sums[a][SUM_W-1] ? quo_t'(-sums[a]) : quo_t'(sums[a]))
                  + quo_t'(count_q >> 1);
      shifted[a]  = {rem[a], quo[a][DIV_W-1]};
      fits[a]     = (shifted[a] >= {1'b0, count_q});
      rem_next[a] = fits[a] ? CNT_W'(shifted[a] - {1'b0, count_q})
                            : shifted[a][CNT_W-1:0];
      quo_next[a] = {quo[a][DIV_W-2:0], fits[a]};
      res[a]      = neg[a] ? (~quo[a] + quo_t'(1)) : quo[a];
    end
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      axis        <= '0;
      slot        <= '0;
      full_q      <= 1'b0;
      bit_cnt     <= '0;
      out_valid_q <= 1'b0;
      cur_stamp   <= '0;
      for (int a = 0; a < AXES; a++) begin
        cur_ang[a]  <= '0;
        prev_ang[a] <= '0;
        sums[a]     <= '0;
      end
    end else begin
      // the final state reloads the output register itself
      if (rate_out.ready && state != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (sample_in.sample_valid) begin
              prev_ang[0] <= cur_ang[0];
              prev_ang[1] <= cur_ang[1];
              prev_ang[2] <= cur_ang[2];
              cur_ang[0]  <= sample_in.yaw_angle;
              cur_ang[1]  <= sample_in.pitch_angle;
              cur_ang[2]  <= sample_in.roll_angle;
              cur_stamp   <= sample_in.sample_time;
            end
            if (sample_in.loop_rate != '0) begin
              freq_q <= sample_in.loop_rate;
              state  <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          for (int a = 0; a < AXES; a++) begin
            diff_q[a] <= d_wrap[a];
          end
          axis  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_q <= diff_q[axis] * $signed({1'b0, freq_q});
          state  <= ST_RND;
        end
        ST_RND: begin
          rate_new[axis] <= prod_shr[RATE_W-1:0];
          if (axis == AXIS_W'(AXES - 1)) begin
            axis  <= '0;
            state <= ST_UPD;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_UPD: begin
          for (int a = 0; a < AXES; a++) begin
            sums[a] <= sum_upd[a];
          end
          if (wrap_end) begin
            slot    <= '0;
            full_q  <= 1'b1;
            count_q <= cnt_t'(WINDOW_DEPTH);
          end else begin
            slot    <= slot_inc[SLOT_W-1:0];
            count_q <= full_q ? cnt_t'(WINDOW_DEPTH) : slot_inc;
          end
          state <= ST_DSET;
        end
        ST_DSET: begin
          for (int a = 0; a < AXES; a++) begin
            quo[a] <= mag[a];
            rem[a] <= '0;
            neg[a] <= sums[a][SUM_W-1];
          end
          bit_cnt <= BITC_W'(DIV_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          for (int a = 0; a < AXES; a++) begin
            quo[a] <= quo_next[a];
            rem[a] <= rem_next[a];
          end
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || rate_out.ready) begin
            for (int a = 0; a < AXES; a++) begin
              out_rate[a] <= res[a][RATE_W-1:0];
            end
            out_stamp   <= cur_stamp;
            out_valid_q <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Rate ring: read the row about to be overwritten on acceptance,
  // write the new row once the sums are updated. The next read only
  // follows after the write, as ticks are taken in idle alone.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row <= hist_mem[slot];
    end
    if (state == ST_UPD) begin
      hist_mem[slot] <= wr_row;
    end
  end

  // A tick with zero loop rate leaves the block idle
  a_zero_rate_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && sample_in.loop_rate == '0 |=> state == ST_IDLE)
    else $error("zero loop rate tick started a computation");

  // Write slot stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot} < (SLOT_W + 1)'(WINDOW_DEPTH))
    else $error("write slot outside the ring");

  // A result word appears only from the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(state == ST_DONE))
    else $error("result word loaded outside the final state");

  // Every divider remainder is below the divisor at the end
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> rem[0] < count_q && rem[1] < count_q && rem[2] < count_q)
    else $error("divider remainder not below fill count");

  // The ring, once full, stays full until reset
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    $fell(full_q) |-> $past(rst))
    else $error("ring full flag cleared without reset");

endmodule

`default_nettype wire

// ----- sim/angular_rate_moving_average_test.sv -----
// Testbench for the angular rate moving average: random compass ticks against a local model.
`timescale 1ns / 1ps

module angular_rate_moving_average_test;
  import armavg_pkg::*;

  localparam longint RATE_LIMIT   = 94371840;
  localparam int     RANDOM_TICKS = 1900;
  localparam int     LIMIT_CYCLES = 600000;
  localparam int     DRAIN_CYCLES = 120;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     HOLD_AT_WORD = 250;
  localparam int     STEADY_FROM  = 700;
  localparam int     STEADY_TO    = 1000;

  // One compass tick as offered on the input channel
  typedef struct {
    logic   sample_valid;
    angle_t yaw;
    angle_t pitch;
    angle_t roll;
    stamp_t stamp;
    freq_t  loop_rate;
  } tick_t;

  // One averaged rate word
  typedef struct {
    rate_t  yaw;
    rate_t  pitch;
    rate_t  roll;
    stamp_t stamp;
  } rate_word_t;

  logic clk;
  logic rst;

  armavg_in_if  sample_if ();
  armavg_out_if rate_if ();

  angular_rate_moving_average DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_if),
    .rate_out  (rate_if)
  );

  tick_t      tick_queue[$];
  rate_word_t expected_rates[$];
  tick_t      on_offer;

  int ticks_total  = 0;
  int ticks_taken  = 0;
  int quiet_ticks  = 0;
  int words_seen   = 0;
  int failures     = 0;
  int cycle_count  = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  // Model state: angles, ring of rates per axis and running sums
  int     cur_angle[3]  = '{0, 0, 0};
  int     prev_angle[3] = '{0, 0, 0};
  stamp_t held_stamp    = '0;
  longint ring_rate[3][WINDOW_DEPTH];
  longint ring_sum[3]   = '{0, 0, 0};
  int     next_slot     = 0;
  bit     ring_full     = 1'b0;

  wire steady = (ticks_taken >= STEADY_FROM) && (ticks_taken < STEADY_TO);

  function automatic longint clamp_rate(longint v);
    if (v > RATE_LIMIT) return RATE_LIMIT;
    if (v < -RATE_LIMIT) return -RATE_LIMIT;
    return v;
  endfunction

  // Wrapped angle difference times frequency, Q.11 to Q.7 rounding half up
  function automatic longint axis_rate(int cur, int prev, freq_t freq);
    longint d;
    longint p;
    d = longint'(cur) - longint'(prev);
    while (d > HALF_TURN) d -= FULL_TURN;
    while (d < -HALF_TURN) d += FULL_TURN;
    p = d * longint'({1'b0, freq}) + 8;
    return clamp_rate(p >>> FRAC_SHIFT);
  endfunction

  // Mean rounded half away from zero
  function automatic longint rounded_mean(longint s, longint n);
    longint q;
    if (s >= 0) q = (s + n / 2) / n;
    else q = -((-s + n / 2) / n);
    return clamp_rate(q);
  endfunction

  // Advance the model by one accepted tick and queue the word it gives
  function automatic void average_tick(tick_t t);
    angle_t     fresh[3];
    longint     r;
    longint     n;
    longint     mean[3];
    rate_word_t w;
    int         a;
    fresh[0] = t.yaw;
    fresh[1] = t.pitch;
    fresh[2] = t.roll;
    if (t.sample_valid) begin
      for (a = 0; a < 3; a++) begin
        prev_angle[a] = cur_angle[a];
        cur_angle[a]  = fresh[a];
      end
      held_stamp = t.stamp;
    end
    // zero loop rate: ring untouched, no word
    if (t.loop_rate == '0) begin
      quiet_ticks++;
      return;
    end
    for (a = 0; a < 3; a++) begin
      r = axis_rate(cur_angle[a], prev_angle[a], t.loop_rate);
      if (ring_full) ring_sum[a] -= ring_rate[a][next_slot];
      ring_rate[a][next_slot] = r;
      ring_sum[a] += r;
    end
    next_slot++;
    if (next_slot >= WINDOW_DEPTH) begin
      next_slot = 0;
      ring_full = 1'b1;
    end
    n = ring_full ? WINDOW_DEPTH : next_slot;
    for (a = 0; a < 3; a++) mean[a] = rounded_mean(ring_sum[a], n);
    w.yaw   = rate_t'(mean[0]);
    w.pitch = rate_t'(mean[1]);
    w.roll  = rate_t'(mean[2]);
    w.stamp = held_stamp;
    expected_rates.push_back(w);
  endfunction

  task automatic queue_tick(logic v, int y, int p, int r, stamp_t s, freq_t f);
    tick_t t;
    t.sample_valid = v;
    t.yaw          = angle_t'(y);
    t.pitch        = angle_t'(p);
    t.roll         = angle_t'(r);
    t.stamp        = s;
    t.loop_rate    = f;
    tick_queue.push_back(t);
    ticks_total++;
  endtask

  function automatic int wrap_angle(int v);
    if (v > 23040) return v - 46080;
    if (v < -23040) return v + 46080;
    return v;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stimulus, reset and end of run
  initial begin
    int     k;
    int     a;
    int     pick;
    int     walk[3];
    stamp_t stamp_clock;
    freq_t  f;

    rst                   = 1'b1;
    sample_if.valid       = 1'b0;
    sample_if.sample_valid = 1'b0;
    sample_if.yaw_angle   = '0;
    sample_if.pitch_angle = '0;
    sample_if.roll_angle  = '0;
    sample_if.sample_time = '0;
    sample_if.loop_rate   = '0;
    rate_if.ready         = 1'b0;

    // Directed: zero loop rate, half-turn edges, field extremes
    queue_tick(1'b1, 0, 0, 0, 32'd0, 16'd0);
    queue_tick(1'b1, 23040, -23040, 0, 32'd1, 16'd16);
    queue_tick(1'b1, -23040, 23040, 32767, 32'd2, 16'hFFFF);
    queue_tick(1'b1, 32767, -32768, -32768, 32'hFFFF_FFFF, 16'hFFFF);
    // invalid tick repeats the old difference; then one with no effect at all
    queue_tick(1'b0, -32768, 32767, 12345, 32'hDEAD_BEEF, 16'd800);
    queue_tick(1'b0, 1, -1, 2, 32'h5555_5555, 16'd0);
    // rounding ties at the smallest loop rate
    queue_tick(1'b1, 0, 0, 0, 32'd10, 16'd1);
    queue_tick(1'b1, 8, -8, 24, 32'd11, 16'd1);
    queue_tick(1'b1, 0, 0, 16, 32'd12, 16'd1);
    // run past the ring depth so old entries drop out of the sums
    walk = '{0, 0, 0};
    for (k = 0; k < 14; k++) begin
      for (a = 0; a < 3; a++) walk[a] = wrap_angle(walk[a] + int'($urandom_range(0, 2000)) - 1000);
      queue_tick(1'b1, walk[0], walk[1], walk[2], 32'd100 + k, (k % 2) ? 16'd800 : 16'd1600);
    end

    // Random: mostly plausible ticks, some noise and quiet ticks
    stamp_clock = 32'd1000;
    for (k = 0; k < RANDOM_TICKS; k++) begin
      pick = $urandom_range(0, 99);
      stamp_clock += $urandom_range(1, 200000);
      if (pick < 6) begin
        queue_tick(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                   freq_t'($urandom));
      end else if (pick < 14) begin
        for (a = 0; a < 3; a++) walk[a] = wrap_angle(walk[a] + int'($urandom_range(0, 3000)) - 1500);
        queue_tick(1'($urandom_range(0, 1)), walk[0], walk[1], walk[2], stamp_clock, 16'd0);
      end else if (pick < 22) begin
        queue_tick(1'b0, $urandom, $urandom, $urandom, $urandom,
                   freq_t'($urandom_range(1, 65535)));
      end else begin
        for (a = 0; a < 3; a++) begin
          if ($urandom_range(0, 9) == 0) walk[a] = int'($urandom_range(0, 46080)) - 23040;
          else walk[a] = wrap_angle(walk[a] + int'($urandom_range(0, 3000)) - 1500);
        end
        if ($urandom_range(0, 9) < 7) f = freq_t'($urandom_range(160, 1600));
        else f = freq_t'($urandom_range(1, 65535));
        queue_tick(1'b1, walk[0], walk[1], walk[2], stamp_clock, f);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (ticks_taken < ticks_total) @(posedge clk);
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d ticks taken, %0d of them with zero loop rate; %0d rate words checked",
             ticks_taken, quiet_ticks, words_seen);
    $display("ring wrap, half-turn wrap, invalid ticks and a %0d-cycle output stall covered",
             HOLD_CYCLES);
    if (failures == 0) begin
      $display("angular_rate_moving_average: match");
    end else begin
      $display("angular_rate_moving_average: mismatch");
    end
    $finish;
  end

  // Driver: offers queued ticks, idling at random outside the steady stretch
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        average_tick(on_offer);
        ticks_taken++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (tick_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          on_offer = tick_queue.pop_front();
          sample_if.valid        <= 1'b1;
          sample_if.sample_valid <= on_offer.sample_valid;
          sample_if.yaw_angle    <= on_offer.yaw;
          sample_if.pitch_angle  <= on_offer.pitch;
          sample_if.roll_angle   <= on_offer.roll;
          sample_if.sample_time  <= on_offer.stamp;
          sample_if.loop_rate    <= on_offer.loop_rate;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each rate word, stalls at random and once for a long stretch
  always @(posedge clk) begin
    rate_word_t w;
    if (rst) begin
      rate_if.ready <= 1'b0;
    end else begin
      if (rate_if.valid && rate_if.ready) begin
        words_seen++;
        if (expected_rates.size() == 0) begin
          $error("rate word with nothing expected: yaw %0d pitch %0d roll %0d time %0d",
                 rate_if.yaw_rate, rate_if.pitch_rate, rate_if.roll_rate, rate_if.rate_time);
          failures++;
        end else begin
          w = expected_rates.pop_front();
          if (rate_if.yaw_rate !== w.yaw) begin
            $error("yaw_rate: expected %0d, got %0d", w.yaw, rate_if.yaw_rate);
            failures++;
          end
          if (rate_if.pitch_rate !== w.pitch) begin
            $error("pitch_rate: expected %0d, got %0d", w.pitch, rate_if.pitch_rate);
            failures++;
          end
          if (rate_if.roll_rate !== w.roll) begin
            $error("roll_rate: expected %0d, got %0d", w.roll, rate_if.roll_rate);
            failures++;
          end
          if (rate_if.rate_time !== w.stamp) begin
            $error("rate_time: expected %0d, got %0d", w.stamp, rate_if.rate_time);
            failures++;
          end
        end
      end
      // long hold-off so the block backs up into its input
      if (!hold_done && words_seen >= HOLD_AT_WORD) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rate_if.ready <= 1'b0;
      end else begin
        rate_if.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("angular_rate_moving_average: mismatch");
      $finish;
    end
  end

endmodule
